### rtl/dem_pkg.sv
package dem_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TAP,
        ST_SQRT,
        ST_ACC,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic store;
        logic tap_start;
        logic tap_step;
        logic sqrt_start;
        logic sqrt_step;
        logic acc;
        logic div_start;
        logic div_step;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic row;
        logic taps_done;
        logic sqrt_done;
        logic div_done;
        logic last;
        logic no_rows;
    } stat_t;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 40;
    localparam int MEAN_W   = 18;
    localparam int ROWS_W   = 17;
    localparam int SQ_W     = 37;
    localparam int ROOT_W   = 19;
    localparam int REM_W    = ROOT_W + 3;
    localparam int IT_W     = 6;

    localparam logic [3:0] EMBED_DIM_RESET = 4'd2;
    localparam logic [4:0] TAP_DELAY_RESET = 5'd1;
    localparam logic [0:0] REG_EMBED_DIM   = 1'b0;
    localparam logic [0:0] REG_TAP_DELAY   = 1'b1;

endpackage

### rtl/dem_stream_if.sv
interface dem_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic               last;
    modport source (output valid, sample_a, sample_b, last, input ready);
    modport sink   (input valid, sample_a, sample_b, last, output ready);
endinterface

interface dem_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] mean_distance;
    logic [16:0] row_count;
    logic        too_short;
    modport source (output valid, mean_distance, row_count, too_short, input ready);
    modport sink   (input valid, mean_distance, row_count, too_short, output ready);
endinterface

### rtl/dem_ctrl.sv
module dem_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  dem_pkg::stat_t stat,
    output dem_pkg::cmd_t  cmd
);
    import dem_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (stat.row)
                begin
                    state_next = ST_TAP;
                end
                else if (stat.last)
                begin
                    state_next = stat.no_rows ? ST_OUT : ST_PREP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAP:
            begin
                if (stat.taps_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = stat.last ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_WRITE:
            begin
                cmd.store     = 1'b1;
                cmd.tap_start = stat.row;
            end
            ST_TAP:
            begin
                cmd.tap_step   = 1'b1;
                cmd.sqrt_start = stat.taps_done;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            ST_PREP:
            begin
                cmd.div_start = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.clear = out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/dem_datapath.sv
module dem_datapath #(
    parameter int MAX_DIM       = 8,
    parameter int MAX_DELAY     = 16,
    parameter int HISTORY_DEPTH = 128,
    parameter int MAX_SAMPLES   = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [3:0]                      embed_dim,
    input  logic [4:0]                      tap_delay,
    input  logic signed [15:0]              in_a,
    input  logic signed [15:0]              in_b,
    input  logic                            in_last,
    input  dem_pkg::cmd_t                   cmd,
    output dem_pkg::stat_t                  stat,
    output logic [17:0]                     mean_distance,
    output logic [16:0]                     row_count,
    output logic                            too_short
);
    import dem_pkg::*;

    localparam int AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SW   = $clog2(MAX_SAMPLES + 1);
    localparam int KW   = $clog2(MAX_DIM + 1);
    localparam int DW   = $clog2(MAX_DELAY + 1);
    localparam int DRED = MAX_DELAY / HISTORY_DEPTH;

    logic [SAMPLE_W-1:0] mem_a [HISTORY_DEPTH];
    logic [SAMPLE_W-1:0] mem_b [HISTORY_DEPTH];
    logic [SAMPLE_W-1:0] rd_a_reg;
    logic [SAMPLE_W-1:0] rd_b_reg;

    logic [SAMPLE_W-1:0] a_reg;
    logic [SAMPLE_W-1:0] b_reg;
    logic                last_reg;
    logic [KW-1:0]       m_reg;
    logic [DW-1:0]       d_reg;
    logic [AW-1:0]       dstep_reg;
    logic [AW-1:0]       wp_reg;
    logic [AW-1:0]       addr_reg;
    logic [SW-1:0]       seen_reg;
    logic [SW-1:0]       rows_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [KW-1:0]       k_reg;
    logic                rdv_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [2*ROOT_W-1:0] sh_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [IT_W-1:0]     it_reg;
    logic [SUM_W-1:0]    q_reg;
    logic [SW-1:0]       drem_reg;

    logic [KW-1:0]    m_eff;
    logic [DW-1:0]    d_eff;
    int               dmod;
    logic [AW-1:0]    dstep;
    logic [31:0]      span;
    logic             store_ok;
    logic [AW-1:0]    addr_step;
    logic [16:0]      diff;
    logic [15:0]      adiff;
    logic [31:0]      prod;
    logic [REM_W-1:0] rem_shift;
    logic [REM_W:0]   trial;
    logic [SW:0]      dshift;
    logic [SW+1:0]    dtrial;

    always_comb
    begin
        m_eff = (embed_dim == 4'd0) ? KW'(1) :
                (32'(embed_dim) > MAX_DIM) ? KW'(MAX_DIM) : KW'(embed_dim);
        d_eff = (tap_delay == 5'd0) ? DW'(1) :
                (32'(tap_delay) > MAX_DELAY) ? DW'(MAX_DELAY) : DW'(tap_delay);
        // tap step reduced modulo the history depth
        dmod = int'(d_eff);
        for (int i = 0; i < DRED; i++)
        begin
            if (dmod >= HISTORY_DEPTH)
            begin
                dmod = dmod - HISTORY_DEPTH;
            end
        end
        dstep     = AW'(dmod);
        span      = (32'(m_reg) - 32'd1) * 32'(d_reg) + 32'd1;
        store_ok  = 32'(seen_reg) < 32'(MAX_SAMPLES);
        addr_step = (addr_reg >= dstep_reg) ? addr_reg - dstep_reg :
                    AW'(32'(addr_reg) + 32'(HISTORY_DEPTH) - 32'(dstep_reg));
        diff      = {rd_a_reg[SAMPLE_W-1], rd_a_reg} - {rd_b_reg[SAMPLE_W-1], rd_b_reg};
        adiff     = diff[16] ? 16'(-diff) : diff[15:0];
        prod      = 32'(adiff) * 32'(adiff);
        rem_shift = {rem_reg[REM_W-3:0], sh_reg[2*ROOT_W-1 -: 2]};
        trial     = {1'b0, rem_shift} - (REM_W+1)'({root_reg, 2'b01});
        dshift    = {drem_reg, q_reg[SUM_W-1]};
        dtrial    = {1'b0, dshift} - (SW+2)'(rows_reg);
    end

    assign stat.row       = store_ok && (32'(seen_reg) + 32'd1 >= span);
    assign stat.taps_done = (k_reg == m_reg) && !rdv_reg;
    assign stat.sqrt_done = (it_reg == IT_W'(ROOT_W - 1));
    assign stat.div_done  = (it_reg == IT_W'(SUM_W - 1));
    assign stat.last      = last_reg;
    assign stat.no_rows   = (rows_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.store && store_ok)
        begin
            mem_a[wp_reg] <= a_reg;
            mem_b[wp_reg] <= b_reg;
        end
        rd_a_reg <= mem_a[addr_reg];
        rd_b_reg <= mem_b[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            last_reg  <= 1'b0;
            m_reg     <= KW'(1);
            d_reg     <= DW'(1);
            dstep_reg <= '0;
            wp_reg    <= '0;
            addr_reg  <= '0;
            seen_reg  <= '0;
            rows_reg  <= '0;
            sum_reg   <= '0;
            k_reg     <= '0;
            rdv_reg   <= 1'b0;
            sq_reg    <= '0;
            sh_reg    <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            it_reg    <= '0;
            q_reg     <= '0;
            drem_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                a_reg     <= in_a;
                b_reg     <= in_b;
                last_reg  <= in_last;
                m_reg     <= m_eff;
                d_reg     <= d_eff;
                dstep_reg <= dstep;
            end
            if (cmd.store && store_ok)
            begin
                wp_reg   <= (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                seen_reg <= seen_reg + SW'(1);
            end
            if (cmd.tap_start)
            begin
                k_reg    <= '0;
                addr_reg <= wp_reg;
                rdv_reg  <= 1'b0;
                sq_reg   <= '0;
            end
            if (cmd.tap_step)
            begin
                if (k_reg != m_reg)
                begin
                    k_reg    <= k_reg + KW'(1);
                    addr_reg <= addr_step;
                    rdv_reg  <= 1'b1;
                end
                else
                begin
                    rdv_reg <= 1'b0;
                end
                if (rdv_reg)
                begin
                    sq_reg <= sq_reg + SQ_W'(prod);
                end
            end
            if (cmd.sqrt_start)
            begin
                sh_reg   <= (2*ROOT_W)'(sq_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                it_reg   <= '0;
            end
            if (cmd.sqrt_step)
            begin
                it_reg <= it_reg + IT_W'(1);
                sh_reg <= {sh_reg[2*ROOT_W-3:0], 2'b00};
                if (!trial[REM_W])
                begin
                    rem_reg  <= trial[REM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            if (cmd.acc)
            begin
                sum_reg  <= sum_reg + SUM_W'(root_reg);
                rows_reg <= rows_reg + SW'(1);
            end
            if (cmd.div_start)
            begin
                q_reg    <= sum_reg;
                drem_reg <= '0;
                it_reg   <= '0;
            end
            if (cmd.div_step)
            begin
                it_reg   <= it_reg + IT_W'(1);
                q_reg    <= {q_reg[SUM_W-2:0], !dtrial[SW+1]};
                drem_reg <= dtrial[SW+1] ? dshift[SW-1:0] : dtrial[SW-1:0];
            end
            if (cmd.clear)
            begin
                wp_reg   <= '0;
                seen_reg <= '0;
                sum_reg  <= '0;
                rows_reg <= '0;
            end
        end
    end

    assign mean_distance = too_short ? '0 : q_reg[MEAN_W-1:0];
    assign row_count     = too_short ? '0 : ROWS_W'(rows_reg);
    assign too_short     = (rows_reg == '0);

endmodule

### rtl/delay_embedding_mean_distance.sv
// sequence: a pair that forms no row is written and the block returns to idle; one that forms a row
// is written, then a tap walk over the m coordinates, a 19-step square root and accumulate
// last item: when too short the result is offered straight after the write; otherwise any row
// is finished first, then the divider is prepared and runs its 40 steps before the result
// throughput: one item at a time, the next taken once the previous one has finished
// reset: rst_n asynchronous active low; history contents undefined until written
module delay_embedding_mean_distance #(
    parameter int MAX_DIM       = 8,
    parameter int MAX_DELAY     = 16,
    parameter int HISTORY_DEPTH = 128,
    parameter int MAX_SAMPLES   = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    dem_in_if.sink      in_ch,
    dem_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import dem_pkg::*;

    logic [3:0] dim_reg;
    logic [4:0] delay_reg;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= EMBED_DIM_RESET;
            delay_reg <= TAP_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_EMBED_DIM)
            begin
                dim_reg <= cfg_data[3:0];
            end
            else if (cfg_index == REG_TAP_DELAY)
            begin
                delay_reg <= cfg_data;
            end
        end
    end

    dem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dem_datapath #(
        .MAX_DIM       (MAX_DIM),
        .MAX_DELAY     (MAX_DELAY),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_SAMPLES   (MAX_SAMPLES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .embed_dim     (dim_reg),
        .tap_delay     (delay_reg),
        .in_a          (in_ch.sample_a),
        .in_b          (in_ch.sample_b),
        .in_last       (in_ch.last),
        .cmd           (cmd),
        .stat          (stat),
        .mean_distance (out_ch.mean_distance),
        .row_count     (out_ch.row_count),
        .too_short     (out_ch.too_short)
    );

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ch.ready && out_ch.valid))
        else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.too_short == (out_ch.row_count == '0)))
        else $error("too_short inconsistent");
`endif

endmodule

### tb/sv/dem_tb_if.sv
`timescale 1ns / 1ps

// channel interfaces come from rtl/dem_stream_if.sv; this file keeps the
// testbench side of the configuration port
interface dem_cfg_if;
    logic       we;
    logic [0:0] index;
    logic [4:0] data;
endinterface

### tb/sv/dem_checker.sv
`timescale 1ns / 1ps

module dem_checker
    import dem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dem_in_if          in_ch,
    dem_out_if         out_ch,
    dem_cfg_if         cfg,
    output int         fail_count,
    output int         pending
);
    localparam int DEPTH = 128;
    localparam int MAXS  = 65536;

    typedef struct packed {
        logic [17:0] mean_distance;
        logic [16:0] row_count;
        logic        too_short;
    } mean_result_t;

    logic [15:0] hist_a [DEPTH];
    logic [15:0] hist_b [DEPTH];
    int unsigned wr_ptr;
    int unsigned seen;
    logic [39:0] dist_sum;
    int unsigned rows;
    logic [3:0]  dim_reg;
    logic [4:0]  delay_reg;
    mean_result_t mean_q[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic take_pair(input logic [15:0] a, input logic [15:0] b, input logic lst);
        int unsigned m;
        int unsigned d;
        int unsigned span;
        int unsigned idx;
        logic [63:0] sq;
        longint diff;
        mean_result_t r;
        m = dim_reg;
        d = delay_reg;
        if (m < 1) m = 1;
        if (m > 8) m = 8;
        if (d < 1) d = 1;
        if (d > 16) d = 16;
        if (seen < MAXS)
        begin
            span = (m - 1) * d + 1;
            hist_a[wr_ptr] = a;
            hist_b[wr_ptr] = b;
            seen++;
            if (seen >= span)
            begin
                sq = 0;
                for (int k = 0; k < m; k++)
                begin
                    idx = (wr_ptr + DEPTH - ((k * d) % DEPTH)) % DEPTH;
                    diff = longint'($signed(hist_a[idx])) - longint'($signed(hist_b[idx]));
                    if (diff < 0) diff = -diff;
                    sq += diff * diff;
                end
                dist_sum = 40'(dist_sum + int_sqrt(sq));
                rows++;
            end
            wr_ptr = (wr_ptr + 1) % DEPTH;
        end
        if (lst)
        begin
            if (rows == 0)
                r = '{18'd0, 17'd0, 1'b1};
            else
            begin
                r.mean_distance = 18'(64'(dist_sum) / rows);
                r.row_count = 17'(rows);
                r.too_short = 1'b0;
            end
            mean_q.insert(mean_q.size(), r);
            wr_ptr = 0;
            seen = 0;
            dist_sum = 0;
            rows = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mean_result_t got;
        mean_result_t want;
        if (!rst_n)
        begin
            wr_ptr = 0;
            seen = 0;
            dist_sum = 0;
            rows = 0;
            dim_reg = EMBED_DIM_RESET;
            delay_reg = TAP_DELAY_RESET;
            fail_count = 0;
            mean_q.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.mean_distance, out_ch.row_count, out_ch.too_short};
                if (mean_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = mean_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                take_pair(in_ch.sample_a, in_ch.sample_b, in_ch.last);
            if (cfg.we)
            begin
                if (cfg.index == REG_EMBED_DIM)
                    dim_reg = cfg.data[3:0];
                else
                    delay_reg = cfg.data;
            end
        end
        pending = mean_q.size();
    end
endmodule

### tb/sv/tb_delay_embedding_mean_distance.sv
`timescale 1ns / 1ps

module tb_delay_embedding_mean_distance;
    import dem_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   sent;
    bit   quiet;

    dem_in_if  in_ch ();
    dem_out_if out_ch ();
    dem_cfg_if cfg ();

    always #5 clk = ~clk;

    delay_embedding_mean_distance u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg.we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data)
    );

    dem_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic lst);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.sample_a <= a;
        in_ch.sample_b <= b;
        in_ch.last     <= lst;
        while (!in_ch.ready)
            @(negedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
        cfg.we    <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(negedge clk);
        cfg.we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    // idle output side in bursts
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #60ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int len;
        in_ch.valid = 1'b0;
        in_ch.sample_a = '0;
        in_ch.sample_b = '0;
        in_ch.last = 1'b0;
        cfg.we = 1'b0;
        cfg.index = REG_EMBED_DIM;
        cfg.data = '0;
        sent = 0;
        quiet = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // too short with reset settings, then extremes
        send_pair(16'h1234, 16'h0000, 1'b1);
        send_pair(16'h8000, 16'h7fff, 1'b0);
        send_pair(16'h7fff, 16'h8000, 1'b0);
        send_pair(16'h8000, 16'h7fff, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'hffff, 16'hffff, 1'b1);
        write_reg(REG_EMBED_DIM, 5'd8);
        write_reg(REG_TAP_DELAY, 5'd16);
        for (int i = 0; i < 114; i++)
            send_pair(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h8000 : 16'h7fff, i == 113);
        write_reg(REG_EMBED_DIM, 5'd0);
        write_reg(REG_TAP_DELAY, 5'd0);
        send_pair(16'h0100, 16'hff00, 1'b1);
        write_reg(REG_EMBED_DIM, 5'd15);
        write_reg(REG_TAP_DELAY, 5'd31);
        send_pair(16'h0100, 16'hff00, 1'b1);

        while (sent < 1950)
        begin
            if (sent > 1700)
                quiet = 1;
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_EMBED_DIM, 5'($urandom_range(0, 15)));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_TAP_DELAY, 5'($urandom_range(0, 31)));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            for (int i = 0; i < len; i++)
                send_pair(rand_sample(), rand_sample(), i == len - 1);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### delay_embedding_mean_distance.f
rtl/dem_pkg.sv
rtl/dem_stream_if.sv
rtl/dem_ctrl.sv
rtl/dem_datapath.sv
rtl/delay_embedding_mean_distance.sv
tb/sv/dem_tb_if.sv
tb/sv/dem_checker.sv
tb/sv/tb_delay_embedding_mean_distance.sv
